// ===== rtl/core/psf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// psf_pkg
// Widths, micro-operations, jump conditions and the control program of the
// prime stream filter.
// ----------------------------------------------------------------------------
package psf_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int VAL_W      = DATA_WIDTH - 1;
	localparam int DIV_W      = DATA_WIDTH / 2 + 1;
	localparam int SQ_W       = 2 * DIV_W;
	localparam int CNT_W      = $clog2(VAL_W);
	localparam int M3_W       = 2 * ((VAL_W + 1) / 2);
	localparam int UC_DEPTH   = 18;
	localparam int PC_W       = $clog2(UC_DEPTH);

	localparam logic [DIV_W-1:0] D_TWO   = DIV_W'(2);
	localparam logic [DIV_W-1:0] D_FIRST = DIV_W'(5);
	localparam logic [DIV_W-1:0] D_STEP  = DIV_W'(6);

	// Multiplying by the inverse of 3 modulo 2**M3_W maps exactly the multiples
	// of 3 onto the values at or below LIM3.
	localparam logic [M3_W-1:0] INV3 = {(M3_W/2){2'b10}} | M3_W'(1);
	localparam logic [M3_W-1:0] LIM3 = {(M3_W/2){2'b01}};

	typedef logic [PC_W-1:0] pc_t;

	typedef enum logic [3:0] {
		UOP_NOP,
		UOP_ACCEPT,
		UOP_SET_D5,
		UOP_SET_DV_D,
		UOP_SET_DV_D2,
		UOP_DIV_STEP,
		UOP_D_ADD6,
		UOP_EMIT_PRIME,
		UOP_EMIT_END
	} uop_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_INPUT,
		C_DONE,
		C_IS_END,
		C_NEG,
		C_LE1,
		C_LE3,
		C_EVEN,
		C_DIV3,
		C_DIV_BUSY,
		C_REM_ZERO,
		C_SQ_GT,
		C_OUT_FULL
	} cond_t;

	typedef struct packed {
		uop_t  uop;
		cond_t cond;
		pc_t   target;
	} ctrl_t;

	localparam pc_t ST_WAIT  = PC_W'(0);
	localparam pc_t ST_LOOP  = PC_W'(8);
	localparam pc_t ST_DIVD  = PC_W'(9);
	localparam pc_t ST_DIVD2 = PC_W'(11);
	localparam pc_t ST_PRIME = PC_W'(14);
	localparam pc_t ST_END   = PC_W'(16);

	// A step jumps to its target when its condition holds and falls through otherwise.
	localparam ctrl_t UCODE [UC_DEPTH] = '{
		'{UOP_ACCEPT,     C_NO_INPUT, ST_WAIT},
		'{UOP_NOP,        C_DONE,     ST_WAIT},
		'{UOP_NOP,        C_IS_END,   ST_END},
		'{UOP_NOP,        C_NEG,      ST_WAIT},
		'{UOP_NOP,        C_LE1,      ST_WAIT},
		'{UOP_NOP,        C_LE3,      ST_PRIME},
		'{UOP_SET_D5,     C_EVEN,     ST_WAIT},
		'{UOP_NOP,        C_DIV3,     ST_WAIT},
		'{UOP_SET_DV_D,   C_SQ_GT,    ST_PRIME},
		'{UOP_DIV_STEP,   C_DIV_BUSY, ST_DIVD},
		'{UOP_SET_DV_D2,  C_REM_ZERO, ST_WAIT},
		'{UOP_DIV_STEP,   C_DIV_BUSY, ST_DIVD2},
		'{UOP_D_ADD6,     C_REM_ZERO, ST_WAIT},
		'{UOP_NOP,        C_ALWAYS,   ST_LOOP},
		'{UOP_EMIT_PRIME, C_OUT_FULL, ST_PRIME},
		'{UOP_NOP,        C_ALWAYS,   ST_WAIT},
		'{UOP_EMIT_END,   C_OUT_FULL, ST_END},
		'{UOP_NOP,        C_ALWAYS,   ST_WAIT}
	};

endpackage
`default_nettype wire

// ===== rtl/core/psf_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// psf_in_if
// Input channel of the prime stream filter: one signed integer per item.
// ----------------------------------------------------------------------------
interface psf_in_if
	import psf_pkg::*;
;
	logic                  valid;
	logic                  ready;
	logic [DATA_WIDTH-1:0] number;

	modport source (output valid, output number, input ready);
	modport sink (input valid, input number, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/psf_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// psf_out_if
// Output channel of the prime stream filter: a prime or the end result.
// ----------------------------------------------------------------------------
interface psf_out_if
	import psf_pkg::*;
;
	logic             valid;
	logic             ready;
	logic [VAL_W-1:0] prime_value;
	logic             end_of_stream;

	modport source (output valid, output prime_value, output end_of_stream, input ready);
	modport sink (input valid, input prime_value, input end_of_stream, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/prime_stream_filter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prime_stream_filter
// Passes on only the primes of a stream of signed integers.
// ----------------------------------------------------------------------------
// The block takes one item at a time on numbers and gives at most one item on
// primes. A value below 2, a negative value and a multiple of 2 or 3 other
// than 2 and 3 give nothing. Other values are tested by trial division with
// divisors 6k-1 and 6k+1 while the divisor squared stays at or below the
// value. The value -1 gives an end item (prime_value 0, end_of_stream 1), and
// every later item is taken and dropped until reset.
// Control is an 18-step microprogram. Multiples of 2 and 3 are found by a bit
// test and a multiply by the inverse of 3; the datapath has one restoring
// divider that yields one quotient bit per cycle. Each accepted item is screened
// by the tests above and, if need be, by trial division with divisor pairs;
// for the largest 31-bit primes about 7720 pairs are tried. numbers.ready is
// high only while the block waits for the next item.
// The result sits in an output register; the block moves on to the next item
// as soon as it has been loaded, and waits only when it has a new result and
// the previous one is still held by a stalled receiver.
// Reset clears the step counter, the output valid and the end flag.
// ----------------------------------------------------------------------------
module prime_stream_filter
	import psf_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	psf_in_if.sink      numbers,
	psf_out_if.source   primes
);

	ctrl_t                 cw;
	pc_t                   pc_q;
	pc_t                   pc_next;
	logic                  cond_true;
	logic [DATA_WIDTH-1:0] num_q;
	logic [VAL_W-1:0]      val;
	logic [DIV_W-1:0]      d_q;
	logic [DIV_W-1:0]      dv_q;
	logic [DIV_W-1:0]      rem_q;
	logic [VAL_W-1:0]      sh_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [SQ_W-1:0]       sq_q;
	logic [M3_W-1:0]       m3_q;
	logic [DIV_W:0]        trial;
	logic [DIV_W:0]        diff;
	logic                  done_q;
	logic                  out_vld_q;
	logic [VAL_W-1:0]      out_val_q;
	logic                  out_eos_q;
	logic                  out_free;
	logic                  emit;
	logic                  div_init;

	assign cw       = UCODE[pc_q];
	assign val      = num_q[VAL_W-1:0];
	assign out_free = !out_vld_q || primes.ready;
	assign emit     = out_free && (cw.uop == UOP_EMIT_PRIME || cw.uop == UOP_EMIT_END);
	assign div_init = cw.uop == UOP_SET_DV_D || cw.uop == UOP_SET_DV_D2;
	assign trial    = {rem_q, sh_q[VAL_W-1]};
	assign diff     = trial - {1'b0, dv_q};

	assign numbers.ready       = cw.uop == UOP_ACCEPT;
	assign primes.valid        = out_vld_q;
	assign primes.prime_value  = out_val_q;
	assign primes.end_of_stream = out_eos_q;

	always_comb begin
		unique case (cw.cond)
			C_NEVER:    cond_true = 1'b0;
			C_ALWAYS:   cond_true = 1'b1;
			C_NO_INPUT: cond_true = !numbers.valid;
			C_DONE:     cond_true = done_q;
			C_IS_END:   cond_true = &num_q;
			C_NEG:      cond_true = num_q[DATA_WIDTH-1];
			C_LE1:      cond_true = val <= VAL_W'(1);
			C_LE3:      cond_true = val <= VAL_W'(3);
			C_EVEN:     cond_true = !val[0];
			C_DIV3:     cond_true = m3_q <= LIM3;
			C_DIV_BUSY: cond_true = cnt_q != CNT_W'(VAL_W - 1);
			C_REM_ZERO: cond_true = rem_q == '0;
			C_SQ_GT:    cond_true = sq_q > SQ_W'(val);
			C_OUT_FULL: cond_true = !out_free;
			default:    cond_true = 1'b0;
		endcase
	end

	always_comb begin
		pc_next = cond_true ? cw.target : pc_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_WAIT;
		end else begin
			pc_q <= pc_next;
		end
	end

	always_ff @(posedge clk) begin
		sq_q <= SQ_W'(d_q) * SQ_W'(d_q);
		m3_q <= M3_W'(val) * INV3;
		if (numbers.valid && numbers.ready) begin
			num_q <= numbers.number;
		end
		unique case (cw.uop)
			UOP_SET_DV_D:  dv_q <= d_q;
			UOP_SET_DV_D2: dv_q <= d_q + D_TWO;
			default:       dv_q <= dv_q;
		endcase
		if (cw.uop == UOP_SET_D5) begin
			d_q <= D_FIRST;
		end else if (cw.uop == UOP_D_ADD6) begin
			d_q <= d_q + D_STEP;
		end
		if (div_init) begin
			rem_q <= '0;
			sh_q  <= val;
			cnt_q <= '0;
		end else if (cw.uop == UOP_DIV_STEP) begin
			rem_q <= diff[DIV_W] ? trial[DIV_W-1:0] : diff[DIV_W-1:0];
			sh_q  <= {sh_q[VAL_W-2:0], 1'b0};
			cnt_q <= cnt_q + 1'b1;
		end
		if (emit) begin
			out_val_q <= (cw.uop == UOP_EMIT_PRIME) ? val : '0;
			out_eos_q <= cw.uop == UOP_EMIT_END;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (primes.ready) begin
				out_vld_q <= 1'b0;
			end
			if (emit && cw.uop == UOP_EMIT_END) begin
				done_q <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/psf_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// psf_checker
// Port-level checks of the prime stream filter, bound to its top level.
// ----------------------------------------------------------------------------
module psf_checker
	import psf_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_ready,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire logic [VAL_W-1:0] prime_value,
	input wire logic             end_of_stream
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(prime_value)
			&& $stable(end_of_stream))
		else $error("Stalled output item changed.");

	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_stream |-> prime_value == '0)
		else $error("End item carries a nonzero value.");

	a_prime_odd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !end_of_stream |-> prime_value[0] || prime_value == VAL_W'(2))
		else $error("Even value other than two passed as prime.");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && end_of_stream |=> !out_valid)
		else $error("Item given right after the end item.");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("Input taken while an item is in work.");

endmodule

bind prime_stream_filter psf_checker u_psf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (numbers.valid),
	.in_ready      (numbers.ready),
	.out_valid     (primes.valid),
	.out_ready     (primes.ready),
	.prime_value   (primes.prime_value),
	.end_of_stream (primes.end_of_stream)
);
`default_nettype wire

// ===== verif/prime_stream_filter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prime_stream_filter_tb
// Drives signed integers into the prime stream filter and checks every item
// that comes out against primality worked out by trial division in the bench.
// Small, odd and large values, negatives and the end marker are covered, with
// random gaps on the sender and random stalls on the receiver.
// ----------------------------------------------------------------------------
module prime_stream_filter_tb;
	import psf_pkg::*;

	localparam int CYCLE_LIMIT = 8_000_000;

	typedef struct {
		logic [DATA_WIDTH-1:0] number;
		bit                    hold;
		bit                    calm;
	} number_item_t;

	typedef struct {
		logic [VAL_W-1:0] prime_value;
		logic             end_of_stream;
	} prime_result_t;

	logic clk = 1'b0;
	logic arst_n;

	psf_in_if  numbers_if ();
	psf_out_if primes_if ();

	prime_stream_filter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.numbers(numbers_if),
		.primes (primes_if)
	);

	number_item_t  pending_numbers[$];
	prime_result_t expected_primes[$];
	bit            stream_ended;
	bit            number_taken;
	bit            quiet;
	bit            calm_phase;
	int            send_gap;
	int            recv_stall;
	int            mismatch_count;
	int            cycle_count;

	always #2 clk = ~clk;

	function automatic bit is_prime_6k(longint unsigned n);
		longint unsigned d;
		if (n <= 1) return 1'b0;
		if (n <= 3) return 1'b1;
		if (n % 2 == 0 || n % 3 == 0) return 1'b0;
		for (d = 5; d * d <= n; d += 6) begin
			if (n % d == 0 || n % (d + 2) == 0) return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic logic [DATA_WIDTH-1:0] pick_6k(int unsigned max_k);
		longint k;
		k = $urandom_range(1, max_k);
		return $urandom_range(0, 1) ? DATA_WIDTH'(6 * k - 1) : DATA_WIDTH'(6 * k + 1);
	endfunction

	task automatic queue_number(input logic [DATA_WIDTH-1:0] value, input bit hold);
		number_item_t item;
		item.number = value;
		item.hold   = hold;
		item.calm   = calm_phase;
		pending_numbers.push_back(item);
	endtask

	always @(negedge clk) begin : number_driver
		number_item_t next;
		if (!arst_n) begin
			numbers_if.valid  <= 1'b0;
			numbers_if.number <= '0;
			send_gap          <= 0;
			quiet             <= 1'b0;
		end else if (!numbers_if.valid || number_taken) begin
			if (send_gap != 0) begin
				numbers_if.valid <= 1'b0;
				send_gap         <= send_gap - 1;
			end else if (pending_numbers.size() != 0 &&
					!(pending_numbers[0].hold && expected_primes.size() != 0)) begin
				next = pending_numbers.pop_front();
				numbers_if.valid  <= 1'b1;
				numbers_if.number <= next.number;
				quiet             <= next.calm;
				if (!next.calm && $urandom_range(0, 3) == 0)
					send_gap <= $urandom_range(1, 7);
			end else begin
				numbers_if.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			primes_if.ready <= 1'b0;
			recv_stall      <= 0;
		end else if (recv_stall != 0) begin
			primes_if.ready <= 1'b0;
			recv_stall      <= recv_stall - 1;
		end else begin
			primes_if.ready <= 1'b1;
			if (!quiet && $urandom_range(0, 5) == 0)
				recv_stall <= $urandom_range(1, 7);
		end
	end

	always @(posedge clk) begin : prime_checker
		prime_result_t want;
		if (primes_if.valid && primes_if.ready) begin
			if (expected_primes.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("Unexpected item: prime_value %0d end_of_stream %0b",
						primes_if.prime_value, primes_if.end_of_stream);
			end else begin
				want = expected_primes.pop_front();
				if (want.prime_value !== primes_if.prime_value ||
						want.end_of_stream !== primes_if.end_of_stream) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("Mismatch: expected %0d/%0b, got %0d/%0b",
							want.prime_value, want.end_of_stream,
							primes_if.prime_value, primes_if.end_of_stream);
				end
			end
		end
		if (arst_n && numbers_if.valid && numbers_if.ready && !stream_ended) begin
			if (numbers_if.number == {DATA_WIDTH{1'b1}}) begin
				stream_ended = 1'b1;
				expected_primes.push_back('{prime_value: '0, end_of_stream: 1'b1});
			end else if (!numbers_if.number[DATA_WIDTH-1] && is_prime_6k(numbers_if.number)) begin
				expected_primes.push_back('{prime_value: numbers_if.number[VAL_W-1:0],
					end_of_stream: 1'b0});
			end
		end
		number_taken <= numbers_if.valid && numbers_if.ready;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles.", cycle_count);
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		logic [DATA_WIDTH-1:0] word;
		int                    pick;
		int                    i;
		arst_n            = 1'b0;
		numbers_if.valid  = 1'b0;
		numbers_if.number = '0;
		primes_if.ready   = 1'b0;
		stream_ended      = 1'b0;
		number_taken      = 1'b0;
		calm_phase        = 1'b0;
		mismatch_count    = 0;
		cycle_count       = 0;

		queue_number(0, 1'b0);
		queue_number(1, 1'b0);
		queue_number(2, 1'b0);
		queue_number(3, 1'b0);
		queue_number(4, 1'b0);
		queue_number(5, 1'b0);
		queue_number(6, 1'b0);
		queue_number(7, 1'b0);
		queue_number(9, 1'b0);
		queue_number(25, 1'b0);
		queue_number(35, 1'b0);
		queue_number(49, 1'b0);
		queue_number(97, 1'b0);
		queue_number(121, 1'b0);
		queue_number(143, 1'b0);
		queue_number(169, 1'b0);
		queue_number(65537, 1'b0);
		queue_number(-2, 1'b0);
		queue_number(-3, 1'b0);
		queue_number(32'h8000_0000, 1'b0);
		queue_number(32'h7FFF_FFFE, 1'b0);
		queue_number(32'h7FFF_FFFD, 1'b0);
		// The largest positive value is prime and runs the divisor loop to its bound.
		queue_number(32'h7FFF_FFFF, 1'b1);

		for (i = 0; i < 72; i++) begin
			calm_phase = (i >= 55);
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				do word = pick_6k(10922); while (!is_prime_6k(word));
			end else if (pick < 55) begin
				word = pick_6k(10922);
			end else if (pick < 65) begin
				word = pick_6k(174762);
			end else if (pick < 72) begin
				word = $urandom_range(0, 40);
			end else if (pick < 86) begin
				word = {1'b1, (DATA_WIDTH-1)'($urandom)};
				if (word == {DATA_WIDTH{1'b1}})
					word[0] = 1'b0;
			end else begin
				word = {1'b0, (DATA_WIDTH-1)'($urandom)};
				case ($urandom_range(0, 2))
					0: begin
						word[0] = 1'b0;
					end
					1: begin
						word = word - word % 3;
					end
					default: begin
						word = word - word % 5;
					end
				endcase
			end
			queue_number(word, i == 0);
		end

		// Everything after the end marker is dropped, a second marker too.
		queue_number(-1, 1'b0);
		queue_number(7, 1'b0);
		queue_number(2, 1'b0);
		queue_number(-1, 1'b0);
		queue_number(13, 1'b0);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_numbers.size() != 0 || numbers_if.valid)
			@(posedge clk);
		while (expected_primes.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);

		if (expected_primes.size() != 0)
			mismatch_count++;
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== prime_stream_filter.f =====
rtl/core/psf_pkg.sv
rtl/core/psf_in_if.sv
rtl/core/psf_out_if.sv
rtl/core/prime_stream_filter.sv
rtl/core/psf_checker.sv
verif/prime_stream_filter_tb.sv
